/* hw/rtl/ibf_pkg.sv */
// ============================================================================
// IIR band-pass filter package
// Shared widths, coefficient defaults, register indexes and item types.
// ============================================================================
`default_nettype none

package ibf_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 20;
    localparam int COEF_FRAC_BITS = 16;
    localparam int HIST_FRAC_BITS = 16;
    localparam int HIST_BITS      = SAMPLE_BITS + HIST_FRAC_BITS;
    localparam int NUM_REGS       = 7;
    localparam int IDX_BITS       = 3;

    // Feed-forward sum: three coefficient-by-sample products.
    localparam int FF_W  = COEF_BITS + SAMPLE_BITS + 2;
    // Full accumulator: feed-forward moved up by the history fraction, minus
    // four coefficient-by-history products, with headroom.
    localparam int ACC_W = COEF_BITS + HIST_BITS + 4;

    localparam logic signed [COEF_BITS-1:0] B0_RESET = 20'sd3079;
    localparam logic signed [COEF_BITS-1:0] B2_RESET = -20'sd6157;
    localparam logic signed [COEF_BITS-1:0] B4_RESET = 20'sd3079;
    localparam logic signed [COEF_BITS-1:0] A1_RESET = -20'sd198889;
    localparam logic signed [COEF_BITS-1:0] A2_RESET = 20'sd250053;
    localparam logic signed [COEF_BITS-1:0] A3_RESET = -20'sd149783;
    localparam logic signed [COEF_BITS-1:0] A4_RESET = 20'sd35750;

    typedef enum logic [IDX_BITS-1:0] {
        REG_B0,
        REG_B2,
        REG_B4,
        REG_A1,
        REG_A2,
        REG_A3,
        REG_A4
    } reg_index_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] b4;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
        logic signed [COEF_BITS-1:0] a3;
        logic signed [COEF_BITS-1:0] a4;
    } coef_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          start_req;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          saturated;
    } out_item_t;

    // Item passed from the front end to the recursion stage.
    typedef struct packed {
        logic signed [FF_W-1:0] ff;
        logic                   clear;
    } cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/ibf_queue.sv */
// ============================================================================
// IIR band-pass filter queue
// Small synchronous FIFO of registers with push/full and pop/empty sides.
// ============================================================================
`default_nettype none

module ibf_queue #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      dout,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= din;
        end
    end

    a_not_full_and_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("queue reports full and empty together");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds its depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on a lone push");

endmodule

`default_nettype wire

/* hw/rtl/ibf_front.sv */
// ============================================================================
// IIR band-pass filter front end
// Keeps the input history and forms the feed-forward sum of each item.
// ============================================================================
`default_nettype none

module ibf_front
    import ibf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire in_item_t item,
    input  wire coef_t    coef,
    output cmd_t          cmd
);

    logic signed [SAMPLE_BITS-1:0] xh_reg [4];
    logic signed [SAMPLE_BITS-1:0] xh_eff [4];
    logic signed [FF_W-1:0]        p0, p2, p4;

    // A start request makes the sample see an all-zero history.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            xh_eff[i] = item.start_req ? '0 : xh_reg[i];
        end
    end

    assign p0 = coef.b0 * item.sample_in;
    assign p2 = coef.b2 * xh_eff[1];
    assign p4 = coef.b4 * xh_eff[3];

    assign cmd.ff    = p0 + p2 + p4;
    assign cmd.clear = item.start_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                xh_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            xh_reg[0] <= item.sample_in;
            xh_reg[1] <= xh_eff[0];
            xh_reg[2] <= xh_eff[1];
            xh_reg[3] <= xh_eff[2];
        end
    end

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.start_req) |=>
            (xh_reg[1] == '0 && xh_reg[2] == '0 && xh_reg[3] == '0))
        else $error("input history not cleared by a start request");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(xh_reg[0]))
        else $error("input history moved without an accepted item");

endmodule

`default_nettype wire

/* hw/rtl/ibf_back.sv */
// ============================================================================
// IIR band-pass filter back end
// Runs the feedback recursion, rounds and saturates, keeps output history.
// ============================================================================
`default_nettype none

module ibf_back
    import ibf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cmd_t  cmd,
    input  wire logic  cmd_ready,
    input  wire logic  out_full,
    input  wire coef_t coef,
    output logic       issue,
    output out_item_t  result
);

    localparam int YR_W = ACC_W - COEF_FRAC_BITS;
    localparam int YS_W = HIST_BITS + 1;
    localparam int SR_W = YS_W - HIST_FRAC_BITS;

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [YS_W-1:0]  HIST_HALF = YS_W'(1) <<< (HIST_FRAC_BITS - 1);

    logic signed [HIST_BITS-1:0] yh_reg [4];
    logic signed [HIST_BITS-1:0] yh_eff [4];
    logic signed [ACC_W-1:0]     ff_ext;
    logic signed [ACC_W-1:0]     fb;
    logic signed [ACC_W-1:0]     acc;
    logic signed [YR_W-1:0]      y_round;
    logic                        y_sat;
    logic signed [HIST_BITS-1:0] y_new;
    logic signed [YS_W-1:0]      y_half;
    logic signed [SR_W-1:0]      s_round;
    logic                        s_sat;

    assign issue = cmd_ready && !out_full;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            yh_eff[i] = cmd.clear ? '0 : yh_reg[i];
        end
    end

    assign ff_ext = ACC_W'(cmd.ff);
    assign fb     = coef.a1 * yh_eff[0] + coef.a2 * yh_eff[1]
                  + coef.a3 * yh_eff[2] + coef.a4 * yh_eff[3];
    assign acc    = (ff_ext <<< HIST_FRAC_BITS) - fb + ACC_HALF;

    // Round half up to the history fraction, then clip to the history width.
    assign y_round = acc[ACC_W-1:COEF_FRAC_BITS];
    assign y_sat   = !((&y_round[YR_W-1:HIST_BITS-1]) || !(|y_round[YR_W-1:HIST_BITS-1]));
    assign y_new   = y_sat ? {y_round[YR_W-1], {(HIST_BITS-1){~y_round[YR_W-1]}}}
                           : y_round[HIST_BITS-1:0];

    // Round half up to an integer sample, then clip to the sample width.
    assign y_half  = YS_W'(y_new) + HIST_HALF;
    assign s_round = y_half[YS_W-1:HIST_FRAC_BITS];
    assign s_sat   = (s_round[SR_W-1] != s_round[SR_W-2]);

    assign result.sample_out = s_sat ? {s_round[SR_W-1], {(SAMPLE_BITS-1){~s_round[SR_W-1]}}}
                                     : s_round[SAMPLE_BITS-1:0];
    assign result.saturated  = y_sat || s_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                yh_reg[i] <= '0;
            end
        end
        else if (issue)
        begin
            yh_reg[0] <= y_new;
            yh_reg[1] <= yh_eff[0];
            yh_reg[2] <= yh_eff[1];
            yh_reg[3] <= yh_eff[2];
        end
    end

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && cmd.clear) |=>
            (yh_reg[1] == '0 && yh_reg[2] == '0 && yh_reg[3] == '0))
        else $error("output history not cleared by a start request");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !issue |=> $stable(yh_reg[0]))
        else $error("output history moved without an issued item");

    a_stored_matches: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> (yh_reg[0] == $past(y_new)))
        else $error("stored history differs from the computed output");

endmodule

`default_nettype wire

/* hw/rtl/iir_bandpass_filter_order4.sv */
// ============================================================================
// Fourth-order IIR band-pass filter
// Direct-form-I filter on signed samples with programmable Q4.16 taps.
// ============================================================================
// Usage: the input side is a queue write port. An item (sample and start
// flag) is taken at a clock edge with push high and full low. A start flag
// clears the input and output history before that sample is filtered.
// The result side is a queue read port: while empty is low the oldest result
// (filtered sample and saturation flag) sits on result, and it is taken at an
// edge with pop high. The coefficients are written through the cfg channel,
// which is always ready; writes belong in idle periods, and an index past the
// last coefficient is ignored.
// Flow: an accepted item is written into the middle queue at the accepting
// edge and is issued from there into the result queue while that queue has
// room; it can be popped once it is the oldest result. Throughput is one
// item per cycle while the result queue is not full, set by the combinational
// feedback loop (four history multiplies, the sum, rounding and clipping).
// When the receiver stops popping, the result queue fills, the recursion
// stage stops, the middle queue fills and full rises; nothing is dropped.
// Reset empties both queues, clears both histories and restores the default
// coefficients.
// ============================================================================
`default_nettype none

module iir_bandpass_filter_order4
    import ibf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire in_item_t             item,
    output logic                      full,
    input  wire logic                 pop,
    output out_item_t                 result,
    output logic                      empty,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [IDX_BITS-1:0]  cfg_index,
    input  wire logic [COEF_BITS-1:0] cfg_data
);

    coef_t     coef_reg, coef_next;
    logic      accept;
    cmd_t      front_cmd;
    cmd_t      back_cmd;
    logic      mid_full;
    logic      mid_empty;
    logic      issue;
    out_item_t back_result;
    logic      out_full;

    // Coefficient registers; the port never stalls.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_B0:  coef_next.b0 = cfg_data;
                REG_B2:  coef_next.b2 = cfg_data;
                REG_B4:  coef_next.b4 = cfg_data;
                REG_A1:  coef_next.a1 = cfg_data;
                REG_A2:  coef_next.a2 = cfg_data;
                REG_A3:  coef_next.a3 = cfg_data;
                REG_A4:  coef_next.a4 = cfg_data;
                default: coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.b0 <= B0_RESET;
            coef_reg.b2 <= B2_RESET;
            coef_reg.b4 <= B4_RESET;
            coef_reg.a1 <= A1_RESET;
            coef_reg.a2 <= A2_RESET;
            coef_reg.a3 <= A3_RESET;
            coef_reg.a4 <= A4_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    // Front end: input history and feed-forward sum, written into the
    // middle queue in the cycle the item is accepted.
    assign full   = mid_full;
    assign accept = push && !mid_full;

    ibf_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .coef   (coef_reg),
        .cmd    (front_cmd)
    );

    ibf_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(cmd_t))
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .din   (front_cmd),
        .full  (mid_full),
        .pop   (issue),
        .dout  (back_cmd),
        .empty (mid_empty)
    );

    // Back end: feedback recursion, one item per cycle while both queues allow.
    ibf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_ready (!mid_empty),
        .out_full  (out_full),
        .coef      (coef_reg),
        .issue     (issue),
        .result    (back_result)
    );

    ibf_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(out_item_t))
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (issue),
        .din   (back_result),
        .full  (out_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

endmodule

`default_nettype wire
